>>> rtl/itoa_pkg.sv
// Shared constants, types and symbol lookup for the integer-to-text converter.
package itoa_pkg;

    localparam int IN_BITS    = 32;
    localparam int SYM_BITS   = 8;
    localparam int NUM_SYMS   = 16;
    localparam int DIGIT_BITS = 4;
    localparam int BASE_BITS  = 5;
    localparam int CHUNK_BITS = 8;
    localparam int REG_BITS   = 64;
    localparam int ADDR_BITS  = 5;

    localparam logic [SYM_BITS-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_BITS-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_BITS-1:0] CHAR_NL    = 8'h0A;

    localparam logic [1:0] REG_SYM_LO   = 2'd0;
    localparam logic [1:0] REG_SYM_HI   = 2'd1;
    localparam logic [1:0] REG_BASE_LEN = 2'd2;

    localparam logic [REG_BITS-1:0]  SYM_LO_RST   = 64'h3736_3534_3332_3130;
    localparam logic [REG_BITS-1:0]  SYM_HI_RST   = 64'h0000_0000_0000_3938;
    localparam logic [BASE_BITS-1:0] BASE_LEN_RST = 5'd10;

    typedef struct packed {
        logic load;
        logic again;
    } t_div_ctl;

    typedef struct packed {
        logic                  done;
        logic                  quot_zero;
        logic [DIGIT_BITS-1:0] rem;
    } t_div_sts;

    function automatic logic [SYM_BITS-1:0] symbol_at(
        input logic [REG_BITS-1:0]   lo,
        input logic [REG_BITS-1:0]   hi,
        input logic [DIGIT_BITS-1:0] idx
    );
        logic [2*REG_BITS-1:0] tbl;
        tbl = {hi, lo};
        return tbl[idx*SYM_BITS +: SYM_BITS];
    endfunction

endpackage

>>> rtl/itoa_tbl_chk.sv
// Symbol table check: length range, sign symbols and repeated symbols.
module itoa_tbl_chk #(
    parameter int MAX_BASE = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [itoa_pkg::REG_BITS-1:0]       i_sym_lo,
    input  logic [itoa_pkg::REG_BITS-1:0]       i_sym_hi,
    input  logic [itoa_pkg::BASE_BITS-1:0]      i_base_len,
    output logic                                o_ok
);

    logic r_ok;
    logic n_ok;

    always_comb begin
        logic                          w_bad;
        logic [itoa_pkg::SYM_BITS-1:0] w_sp;
        w_bad = (i_base_len < itoa_pkg::BASE_BITS'(2)) ||
                (i_base_len > itoa_pkg::BASE_BITS'(MAX_BASE));
        for (int p = 0; p < itoa_pkg::NUM_SYMS; p++) begin
            w_sp = itoa_pkg::symbol_at(i_sym_lo, i_sym_hi, itoa_pkg::DIGIT_BITS'(p));
            if (itoa_pkg::BASE_BITS'(p) < i_base_len) begin
                if (w_sp == itoa_pkg::CHAR_PLUS || w_sp == itoa_pkg::CHAR_MINUS) begin
                    w_bad = 1'b1;
                end
                for (int q = p + 1; q < itoa_pkg::NUM_SYMS; q++) begin
                    if ((itoa_pkg::BASE_BITS'(q) < i_base_len) &&
                        (itoa_pkg::symbol_at(i_sym_lo, i_sym_hi,
                                             itoa_pkg::DIGIT_BITS'(q)) == w_sp)) begin
                        w_bad = 1'b1;
                    end
                end
            end
        end
        n_ok = !w_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= 1'b0;
        end else begin
            r_ok <= n_ok;
        end
    end

    assign o_ok = r_ok;

endmodule

>>> rtl/itoa_div.sv
// Shared divider: divides by the base one byte of the dividend per cycle.
module itoa_div #(
    parameter int W = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  itoa_pkg::t_div_ctl              i_ctl,
    input  logic [W-1:0]                    i_dividend,
    input  logic [itoa_pkg::BASE_BITS-1:0]  i_base,
    output itoa_pkg::t_div_sts              o_sts
);

    localparam int CHUNK = itoa_pkg::CHUNK_BITS;
    localparam int STEPS = W / CHUNK;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [W-1:0]                     r_acc;
    logic [W-1:0]                     n_acc;
    logic [itoa_pkg::DIGIT_BITS-1:0]  r_rem;
    logic [itoa_pkg::DIGIT_BITS-1:0]  n_rem;
    logic [CNT_W-1:0]                 r_cnt;
    logic [CNT_W-1:0]                 n_cnt;
    logic                             r_run;
    logic                             n_run;
    logic                             r_done;
    logic                             n_done;
    logic [CHUNK-1:0]                 w_chunk;
    logic [CHUNK-1:0]                 w_q;
    logic [W+CHUNK-1:0]               w_cat;
    logic [itoa_pkg::BASE_BITS-1:0]   w_part;
    logic [itoa_pkg::DIGIT_BITS-1:0]  w_rem;

    // restoring division over one byte
    always_comb begin
        w_chunk = r_acc[W-1 -: CHUNK];
        w_rem   = r_rem;
        w_q     = '0;
        w_part  = '0;
        for (int k = CHUNK - 1; k >= 0; k--) begin
            w_part = {w_rem, w_chunk[k]};
            if (w_part >= i_base) begin
                w_part = w_part - i_base;
                w_q[k] = 1'b1;
            end
            w_rem = w_part[itoa_pkg::DIGIT_BITS-1:0];
        end
        w_cat = {r_acc, w_q};
    end

    always_comb begin
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_ctl.load) begin
            n_acc = i_dividend;
            n_rem = '0;
            n_cnt = '0;
            n_run = 1'b1;
        end else if (i_ctl.again) begin
            n_rem = '0;
            n_cnt = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            n_acc = w_cat[W-1:0];
            n_rem = w_rem;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_rem <= n_rem;
    end

    assign o_sts.done      = r_done;
    assign o_sts.quot_zero = (r_acc == '0);
    assign o_sts.rem       = r_rem;

endmodule

>>> rtl/itoa_stack.sv
// Digit stack memory with registered read.
module itoa_stack #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [AW-1:0]                    i_waddr,
    input  logic [itoa_pkg::DIGIT_BITS-1:0]  i_wdata,
    input  logic                             i_re,
    input  logic [AW-1:0]                    i_raddr,
    output logic [itoa_pkg::DIGIT_BITS-1:0]  o_rdata
);

    logic [itoa_pkg::DIGIT_BITS-1:0] r_mem [DEPTH];
    logic [itoa_pkg::DIGIT_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/integer_to_text_any_base.sv
// Integer-to-text converter top level: register port, sequencer and output.
// Per digit the shared divider steps through the value one byte at a time, ceil(VALUE_BITS/8) bytes (4 at 32 bits).
// Busy stays high until the last digit is read from the stack; a new item is accepted only while busy is low.
// For a negative value the minus sign leaves before the first digit; the digits then follow one a cycle.
// A bad table: a newline, marked last, in place of the text. Results are strobed once and cannot stall.
// Reset clears the sequencer and strobe and restores the decimal symbol table.
module integer_to_text_any_base #(
    parameter int MAX_BASE   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [itoa_pkg::IN_BITS-1:0]   i_value,
    output logic                                  o_strobe,
    output logic [itoa_pkg::SYM_BITS-1:0]         o_char_out,
    output logic                                  o_last,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [itoa_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [itoa_pkg::REG_BITS-1:0]         pwdata,
    output logic [itoa_pkg::REG_BITS-1:0]         prdata,
    output logic                                  pready
);

    localparam int CHUNK = itoa_pkg::CHUNK_BITS;
    localparam int DIV_W = ((VALUE_BITS + CHUNK - 1) / CHUNK) * CHUNK;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int AW    = $clog2(VALUE_BITS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [itoa_pkg::REG_BITS-1:0]   r_sym_lo;
    logic [itoa_pkg::REG_BITS-1:0]   r_sym_hi;
    logic [itoa_pkg::BASE_BITS-1:0]  r_base_len;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic [VALUE_BITS-1:0]           r_mag;
    logic [VALUE_BITS-1:0]           n_mag;
    logic                            r_neg;
    logic                            n_neg;
    logic [CNT_W-1:0]                r_dcnt;
    logic [CNT_W-1:0]                n_dcnt;
    logic                            r_rdv;
    logic                            n_rdv;
    logic                            r_rdlast;
    logic                            n_rdlast;
    logic                            r_strobe;
    logic                            n_strobe;
    logic [itoa_pkg::SYM_BITS-1:0]   r_char;
    logic [itoa_pkg::SYM_BITS-1:0]   n_char;
    logic                            r_last;
    logic                            n_last;

    logic                            w_wr;
    logic                            w_busy;
    logic                            w_ok;
    logic [VALUE_BITS-1:0]           w_raw;
    logic                            w_neg;
    logic [VALUE_BITS-1:0]           w_mag;
    logic [CNT_W-1:0]                w_dprev;
    itoa_pkg::t_div_ctl              w_ctl;
    itoa_pkg::t_div_sts              w_sts;
    logic                            w_we;
    logic                            w_re;
    logic [itoa_pkg::DIGIT_BITS-1:0] w_rdata;

    // register port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_lo   <= itoa_pkg::SYM_LO_RST;
            r_sym_hi   <= itoa_pkg::SYM_HI_RST;
            r_base_len <= itoa_pkg::BASE_LEN_RST;
        end else if (w_wr) begin
            case (paddr[4:3])
                itoa_pkg::REG_SYM_LO:   r_sym_lo   <= pwdata;
                itoa_pkg::REG_SYM_HI:   r_sym_hi   <= pwdata;
                itoa_pkg::REG_BASE_LEN: r_base_len <= pwdata[itoa_pkg::BASE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            itoa_pkg::REG_SYM_LO:   prdata = r_sym_lo;
            itoa_pkg::REG_SYM_HI:   prdata = r_sym_hi;
            itoa_pkg::REG_BASE_LEN: prdata = itoa_pkg::REG_BITS'(r_base_len);
            default:                prdata = '0;
        endcase
    end

    itoa_tbl_chk #(
        .MAX_BASE   (MAX_BASE)
    ) u_tbl_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sym_lo   (r_sym_lo),
        .i_sym_hi   (r_sym_hi),
        .i_base_len (r_base_len),
        .o_ok       (w_ok)
    );

    itoa_div #(
        .W          (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_dividend (DIV_W'(r_mag)),
        .i_base     (r_base_len),
        .o_sts      (w_sts)
    );

    itoa_stack #(
        .DEPTH   (VALUE_BITS),
        .AW      (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_dcnt[AW-1:0]),
        .i_wdata (w_sts.rem),
        .i_re    (w_re),
        .i_raddr (w_dprev[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_raw   = i_value[VALUE_BITS-1:0];
    assign w_neg   = w_raw[VALUE_BITS-1];
    assign w_mag   = w_neg ? ((~w_raw) + VALUE_BITS'(1)) : w_raw;
    assign w_dprev = r_dcnt - 1'b1;
    assign w_busy  = (r_state != S_IDLE) || r_rdv;
    assign busy    = w_busy;

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_dcnt   = r_dcnt;
        n_rdv    = 1'b0;
        n_rdlast = r_rdlast;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        w_ctl    = '0;
        w_we     = 1'b0;
        w_re     = 1'b0;

        // drive the read digit out
        if (r_rdv) begin
            n_strobe = 1'b1;
            n_char   = itoa_pkg::symbol_at(r_sym_lo, r_sym_hi, w_rdata);
            n_last   = r_rdlast;
        end

        case (r_state)
            S_IDLE: begin
                if (start && !w_busy) begin
                    n_mag   = w_mag;
                    n_neg   = w_neg;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!w_ok) begin
                    n_strobe = 1'b1;
                    n_char   = itoa_pkg::CHAR_NL;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    w_ctl.load = 1'b1;
                    n_dcnt     = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (w_sts.done) begin
                    w_we   = 1'b1;
                    n_dcnt = r_dcnt + 1'b1;
                    if (w_sts.quot_zero) begin
                        if (r_neg) begin
                            n_strobe = 1'b1;
                            n_char   = itoa_pkg::CHAR_MINUS;
                            n_last   = 1'b0;
                        end
                        n_state = S_EMIT;
                    end else begin
                        w_ctl.again = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                w_re     = 1'b1;
                n_dcnt   = w_dprev;
                n_rdv    = 1'b1;
                n_rdlast = (r_dcnt == CNT_W'(1));
                if (r_dcnt == CNT_W'(1)) begin
                    n_mag   = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mag    <= '0;
            r_dcnt   <= '0;
            r_rdv    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mag    <= n_mag;
            r_dcnt   <= n_dcnt;
            r_rdv    <= n_rdv;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg    <= n_neg;
        r_rdlast <= n_rdlast;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    assign o_strobe   = r_strobe;
    assign o_char_out = r_char;
    assign o_last     = r_last;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low after an accepted item");

    a_last_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !r_rdv && (r_state == S_IDLE))
        else $error("final character with work still pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_dcnt < CNT_W'(VALUE_BITS))
        else $error("digit count beyond stack depth");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_dcnt != '0)
        else $error("emit with empty digit stack");

endmodule
